/* rtl/lslc_pkg.sv */
// Package: shared types, constants and trig table builder for the scan clustering core.
`default_nettype none
package lslc_pkg;

  localparam int BEAMS_PER_SCAN_DEF = 720;
  localparam int MAX_CENTROIDS_DEF  = 32;
  localparam int TRIG_DEPTH         = 1024;
  localparam int CW                 = 18;
  localparam int TSQ_W              = 32;
  localparam int SQ_W               = 38;
  localparam logic [15:0] THRESH_RST = 16'd2867;
  localparam logic [5:0]  SPB_RST    = 6'd20;
  localparam logic        REG_THRESH = 1'b0;
  localparam logic        REG_SPB    = 1'b1;

  localparam longint ROT_COS  = 64'sd1073701188;
  localparam longint ROT_SIN  = 64'sd9341436;
  localparam longint TRIG_ONE = 64'sd1073741824;
  localparam longint HALF_Q30 = 64'sd536870912;

  typedef logic signed [31:0] trig_tab_t [TRIG_DEPTH];

  typedef struct packed {
    logic                 v;
    logic                 done;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } token_t;

  typedef struct packed {
    logic                 v;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } cent_t;

  // rotation recurrence, Q1.30, rounded to nearest with floor
  function automatic trig_tab_t build_trig(input bit want_sin);
    trig_tab_t tab;
    longint c;
    longint s;
    longint nc;
    longint ns;
    c = TRIG_ONE;
    s = 0;
    for (int i = 0; i < TRIG_DEPTH; i++) begin
      tab[i] = want_sin ? s[31:0] : c[31:0];
      nc = (c * ROT_COS - s * ROT_SIN + HALF_Q30) >>> 30;
      ns = (s * ROT_COS + c * ROT_SIN + HALF_Q30) >>> 30;
      c = nc;
      s = ns;
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

/* rtl/lslc_cell.sv */
// One centroid cell: distance test, merge or claim, and neighbor shift for readout.
`default_nettype none
module lslc_cell (
  input  wire                        clk,
  input  wire                        rst,
  input  wire lslc_pkg::token_t      tok_in,
  input  wire [lslc_pkg::TSQ_W-1:0]  tsq,
  input  wire                        shift_en,
  input  wire lslc_pkg::cent_t       shift_in,
  output lslc_pkg::token_t           tok_out,
  output lslc_pkg::cent_t            cent
);

  lslc_pkg::token_t a_tok;
  logic [lslc_pkg::SQ_W-1:0] a_dx2;
  logic [lslc_pkg::SQ_W-1:0] a_dy2;
  logic signed [lslc_pkg::CW:0] dx;
  logic signed [lslc_pkg::CW:0] dy;
  logic signed [2*lslc_pkg::CW+1:0] dx2;
  logic signed [2*lslc_pkg::CW+1:0] dy2;
  logic [lslc_pkg::SQ_W:0] dsum;
  logic live;
  logic match;
  logic take;
  logic signed [lslc_pkg::CW:0] sx;
  logic signed [lslc_pkg::CW:0] sy;

  always_comb begin
    dx   = {tok_in.x[lslc_pkg::CW-1], tok_in.x} - {cent.x[lslc_pkg::CW-1], cent.x};
    dy   = {tok_in.y[lslc_pkg::CW-1], tok_in.y} - {cent.y[lslc_pkg::CW-1], cent.y};
    dx2  = dx * dx;
    dy2  = dy * dy;
    dsum = {1'b0, a_dx2} + {1'b0, a_dy2};
    live = a_tok.v && !a_tok.done;
    match = live && cent.v && (dsum < {{(lslc_pkg::SQ_W+1-lslc_pkg::TSQ_W){1'b0}}, tsq});
    take  = live && !cent.v;
    sx = {a_tok.x[lslc_pkg::CW-1], a_tok.x} + {cent.x[lslc_pkg::CW-1], cent.x};
    sy = {a_tok.y[lslc_pkg::CW-1], a_tok.y} + {cent.y[lslc_pkg::CW-1], cent.y};
  end

  always_ff @(posedge clk) begin
    a_tok <= tok_in;
    a_dx2 <= dx2[lslc_pkg::SQ_W-1:0];
    a_dy2 <= dy2[lslc_pkg::SQ_W-1:0];
    tok_out <= a_tok;
    tok_out.done <= a_tok.done || match || take;
    if (shift_en) begin
      cent <= shift_in;
    end else if (match) begin
      cent.x <= sx[lslc_pkg::CW:1];
      cent.y <= sy[lslc_pkg::CW:1];
    end else if (take) begin
      cent.v <= 1'b1;
      cent.x <= a_tok.x;
      cent.y <= a_tok.y;
    end
    if (rst) begin
      a_tok.v   <= 1'b0;
      tok_out.v <= 1'b0;
      cent.v    <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* rtl/lslc_chain.sv */
// Row of centroid cells; points ripple down, readout shifts toward cell zero.
`default_nettype none
module lslc_chain #(
  parameter int MAX_CENTROIDS = lslc_pkg::MAX_CENTROIDS_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire lslc_pkg::token_t      tok_in,
  input  wire [lslc_pkg::TSQ_W-1:0]  tsq,
  input  wire                        shift_en,
  output lslc_pkg::token_t           tok_out,
  output lslc_pkg::cent_t            head,
  output lslc_pkg::cent_t            head_next,
  output logic [MAX_CENTROIDS-1:0]   vvec
);

  lslc_pkg::token_t tk [MAX_CENTROIDS+1];
  lslc_pkg::cent_t  cs [MAX_CENTROIDS+1];

  assign tk[0] = tok_in;
  assign cs[MAX_CENTROIDS] = '0;

  for (genvar j = 0; j < MAX_CENTROIDS; j++) begin : g_cell
    lslc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tk[j]),
      .tsq      (tsq),
      .shift_en (shift_en),
      .shift_in (cs[j+1]),
      .tok_out  (tk[j+1]),
      .cent     (cs[j])
    );
    assign vvec[j] = cs[j].v;
  end

  assign tok_out   = tk[MAX_CENTROIDS];
  assign head      = cs[0];
  assign head_next = cs[1];

endmodule
`default_nettype wire

/* rtl/laser_scan_leader_clustering_core.sv */
// Top level: laser scan leader clustering core.
// Each beat is one range sample; a beat with a return is turned to x,y through a
// cosine/sine ROM and one multiply stage, then ripples down a row of
// MAX_CENTROIDS cells, where the first close centroid merges it or the first
// free cell takes it. The core takes no new sample until the current one has
// rippled through the whole cell row.
// At the end of a batch the row shifts out one centroid per beat on the output.
`default_nettype none
module laser_scan_leader_clustering_core #(
  parameter int BEAMS_PER_SCAN = lslc_pkg::BEAMS_PER_SCAN_DEF,
  parameter int MAX_CENTROIDS  = lslc_pkg::MAX_CENTROIDS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // range_sample[15:0], beam_index[25:16]
  input  wire         s_tuser,   // has_return
  input  wire         s_tlast,   // end_of_scan
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // centroid_x[16:0], centroid_y[33:17]
  output logic [1:0]  m_tuser,   // has_centroid, overflow
  output logic        m_tlast,   // last
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [15:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_INJ  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam int WAIT_N = 2 * MAX_CENTROIDS + 1;
  localparam int WW = $clog2(WAIT_N + 1);
  localparam lslc_pkg::trig_tab_t COS_TAB = lslc_pkg::build_trig(1'b0);
  localparam lslc_pkg::trig_tab_t SIN_TAB = lslc_pkg::build_trig(1'b1);

  logic [2:0]  state;
  logic [15:0] thresh;
  logic [5:0]  spb;
  logic [lslc_pkg::TSQ_W-1:0] tsq;
  logic [15:0] range_q;
  logic        pt_ok;
  logic        eos_q;
  logic signed [31:0] cos_q;
  logic signed [31:0] sin_q;
  logic signed [48:0] prod_x;
  logic signed [48:0] prod_y;
  logic signed [48:0] rnd_x;
  logic signed [48:0] rnd_y;
  logic [WW-1:0] wait_cnt;
  logic [5:0]  scan_cnt;
  logic [5:0]  scan_next;
  logic [5:0]  limit;
  logic        ovf;
  logic        accept;
  logic        load;
  logic        shift_en;
  lslc_pkg::token_t tok_in;
  lslc_pkg::token_t tok_out;
  lslc_pkg::cent_t  head;
  lslc_pkg::cent_t  head_next;
  logic [MAX_CENTROIDS-1:0] vvec;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load     = !m_tvalid || m_tready;
  assign shift_en = (state == ST_EMIT) && load && head.v;
  assign scan_next = scan_cnt + 6'd1;
  assign limit    = (spb == 6'd0) ? 6'd1 : spb;

  always_comb begin
    rnd_x = (prod_x + 49'sd536870912) >>> 30;
    rnd_y = (prod_y + 49'sd536870912) >>> 30;
    tok_in = '0;
    if (state == ST_INJ) begin
      tok_in.v = pt_ok;
      tok_in.x = rnd_x[lslc_pkg::CW-1:0];
      tok_in.y = rnd_y[lslc_pkg::CW-1:0];
    end
  end

  lslc_chain #(.MAX_CENTROIDS(MAX_CENTROIDS)) u_chain (
    .clk       (clk),
    .rst       (rst),
    .tok_in    (tok_in),
    .tsq       (tsq),
    .shift_en  (shift_en),
    .tok_out   (tok_out),
    .head      (head),
    .head_next (head_next),
    .vvec      (vvec)
  );

  always_ff @(posedge clk) begin
    tsq <= {16'd0, thresh} * {16'd0, thresh};
    if (accept) begin
      range_q <= s_tdata[15:0];
      eos_q   <= s_tlast;
      pt_ok   <= s_tuser && ({22'd0, s_tdata[25:16]} < BEAMS_PER_SCAN);
      cos_q   <= COS_TAB[s_tdata[25:16]];
      sin_q   <= SIN_TAB[s_tdata[25:16]];
    end
    prod_x <= $signed({1'b0, range_q}) * cos_q;
    prod_y <= $signed({1'b0, range_q}) * sin_q;
    if (cfg_we) begin
      if (cfg_index == lslc_pkg::REG_THRESH) thresh <= cfg_data;
      if (cfg_index == lslc_pkg::REG_SPB)    spb    <= cfg_data[5:0];
    end
    if (tok_out.v && !tok_out.done) ovf <= 1'b1;
    if (m_tvalid && m_tready) m_tvalid <= 1'b0;
    case (state)
      ST_IDLE: if (accept) state <= ST_MUL;
      ST_MUL:  state <= ST_INJ;
      ST_INJ: begin
        wait_cnt <= WW'(WAIT_N);
        state    <= ST_WAIT;
      end
      ST_WAIT: begin
        if (wait_cnt != '0) begin
          wait_cnt <= wait_cnt - 1'b1;
        end else if (!eos_q) begin
          state <= ST_IDLE;
        end else if (scan_next >= limit) begin
          scan_cnt <= scan_next;
          state    <= ST_EMIT;
        end else begin
          scan_cnt <= scan_next;
          state    <= ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (load) begin
          m_tvalid <= 1'b1;
          m_tdata  <= head.v ? {6'd0, head.y[16:0], head.x[16:0]} : '0;
          m_tuser  <= {ovf, head.v};
          m_tlast  <= !head.v || !head_next.v;
          if (!head.v || !head_next.v) begin
            scan_cnt <= '0;
            ovf      <= 1'b0;
            state    <= ST_IDLE;
          end
        end
      end
      default: state <= ST_IDLE;
    endcase
    if (rst) begin
      state    <= ST_IDLE;
      thresh   <= lslc_pkg::THRESH_RST;
      spb      <= lslc_pkg::SPB_RST;
      scan_cnt <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
      wait_cnt <= '0;
    end
  end

  a_contig: assert property (@(posedge clk) disable iff (rst)
    (vvec & (vvec + 1'b1)) == '0)
    else $error("centroid cells not filled in order");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    tok_out.v && !tok_out.done |-> vvec[MAX_CENTROIDS-1])
    else $error("point dropped while a cell was free");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat lost");

  a_no_shift_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_EMIT |-> !shift_en)
    else $error("cell row shifted outside readout");

endmodule
`default_nettype wire
